/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/slu_pkg.sv */
// ---------------------------------------------------------------------------
// slu_pkg
// Shared types and constants of the simplex Lion update step.
// ---------------------------------------------------------------------------
package slu_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam logic [15:0] STEP_RATE_RST = 16'd655;
    localparam logic [15:0] BLEND_RST     = 16'd58982;
    localparam logic [15:0] MDECAY_RST    = 16'd65470;
    localparam logic [15:0] WDECAY_RST    = 16'd655;

    localparam logic [32:0] ONE_Q16   = 33'd65536;
    localparam logic [32:0] LN2_Q16   = 33'd45426;
    localparam logic [32:0] LOG2E_Q16 = 33'd94548;

    localparam int XW     = 24;
    localparam int EW     = 31;
    localparam int SUM_W  = 37;
    localparam int ACC_W  = 61;
    localparam int CFG_IW = 3;

    localparam logic signed [XW-1:0] LOG_FLOOR = 24'sh800000;
    localparam logic signed [XW-1:0] LOG_CEIL  = 24'sh7FFFFF;

    typedef enum logic [CFG_IW-1:0] {
        CFG_STEP_RATE = 3'd0,
        CFG_BLEND     = 3'd1,
        CFG_MDECAY    = 3'd2,
        CFG_WDECAY    = 3'd3
    } cfg_idx_t;

    typedef enum logic {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_ctl_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_LMAX, ST_LG_SQ, ST_LG_AC,
        ST_E_RD, ST_E_LD, ST_E_F, ST_E_GA, ST_E_A1, ST_E_A2, ST_E_M1, ST_E_M2,
        ST_E_LN, ST_E_X, ST_E_WD, ST_E_S, ST_E_X2,
        ST_X_RD, ST_X_LD, ST_X_T, ST_X_SQ, ST_X_SQW, ST_X_E,
        ST_D_RD, ST_D_ST, ST_D_W, ST_D_OUT
    } state_t;

endpackage

/* src/slu_ram.sv */
// ---------------------------------------------------------------------------
// slu_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module slu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/slu_mul.sv */
// ---------------------------------------------------------------------------
// slu_mul
// Shared signed 33x33 multiplier with registered product.
// ---------------------------------------------------------------------------
module slu_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* src/slu_iter.sv */
// ---------------------------------------------------------------------------
// slu_iter
// Shared compare-subtract step unit: bitwise integer square root (31 steps)
// or restoring division with a 17-bit quotient (17 steps).
// ---------------------------------------------------------------------------
module slu_iter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slu_pkg::iter_ctl_t        ctl,
    input  logic [slu_pkg::ACC_W-1:0] op_a,
    input  logic [slu_pkg::SUM_W-1:0] op_b,
    output logic                      done,
    output logic [slu_pkg::EW-1:0]    result
);
    import slu_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    iter_mode_t       mode_reg, mode_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] res_reg, res_next;
    logic [ACC_W-1:0] bit_reg, bit_next;
    logic [ACC_W:0]   cand;
    logic             ge;

    always_comb
    begin
        cand = (mode_reg == ITER_SQRT) ? ({1'b0, res_reg} + {1'b0, bit_reg})
                                       : {1'b0, bit_reg};
        ge        = {1'b0, acc_reg} >= cand;
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.mode;
            acc_next  = op_a;
            res_next  = '0;
            if (ctl.mode == ITER_SQRT)
            begin
                bit_next = ACC_W'(1) << (ACC_W - 1);
                cnt_next = 5'd30;
            end
            else
            begin
                bit_next = ACC_W'({op_b, 16'b0});
                cnt_next = 5'd16;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                acc_next = acc_reg - cand[ACC_W-1:0];
            end
            if (mode_reg == ITER_SQRT)
            begin
                res_next = ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
                bit_next = bit_reg >> 2;
            end
            else
            begin
                res_next = {res_reg[ACC_W-2:0], ge};
                bit_next = bit_reg >> 1;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= ITER_SQRT;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done   = done_reg;
    assign result = res_reg[EW-1:0];

endmodule

/* src/simplex_lion_update_step.sv */
// ---------------------------------------------------------------------------
// simplex_lion_update_step
// One simplex-constrained Lion iteration per loaded vector, softmax output.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | weight, gradient; tuser fresh_start; tlast last_element
//  m_axis   | out       | new_weight, element_index; tlast last_result
//  cfg      | in        | register index, 16-bit value
//
// Loading takes one cycle per item. On the last item the vector update starts:
// per element 16 square roots of 31 steps in the shared step unit dominate,
// and each log runs on the shared multiplier; a zero weight skips the log.
// s_axis_tready is low from the last item until the final result transfer.
// Momentum resets to zero through per-slot valid bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module simplex_lion_update_step #(
    parameter int MAX_LEN = slu_pkg::MAX_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [55:0]                s_axis_tdata,  // weight[16:0], gradient[48:17]
    input  logic                       s_axis_tuser,  // fresh_start
    input  logic                       s_axis_tlast,  // last_element
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // new_weight[16:0], element_index[22:17]
    output logic                       m_axis_tlast,  // last_result
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [slu_pkg::CFG_IW-1:0] cfg_index,
    input  logic [15:0]                cfg_data
);
    import slu_pkg::*;

    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    state_t                state_reg, state_next;
    logic [15:0]           lr_reg, lr_next, b1_reg, b1_next;
    logic [15:0]           b2_reg, b2_next, wd_reg, wd_next;
    logic [CW-1:0]         count_reg, count_next, i_reg, i_next, n_reg, n_next;
    logic [16:0]           largest_reg, largest_next;
    logic [MAX_LEN-1:0]    mvalid_reg, mvalid_next;
    logic                  lsrc_max_reg, lsrc_max_next;
    logic [20:0]           lmax_reg, lmax_next, logw_reg, logw_next;
    logic [30:0]           lg_m_reg, lg_m_next;
    logic [4:0]            lg_e_reg, lg_e_next;
    logic [15:0]           lg_frac_reg, lg_frac_next;
    logic [3:0]            lg_cnt_reg, lg_cnt_next;
    logic [16:0]           w_reg, w_next;
    logic signed [31:0]    g_reg, g_next, m_reg, m_next, ga_reg, ga_next;
    logic signed [65:0]    acc_reg, acc_next;
    logic signed [17:0]    s_reg, s_next;
    logic signed [XW-1:0]  x_reg, x_next, xmax_reg, xmax_next;
    logic [4:0]            ip_reg, ip_next;
    logic                  ipbig_reg, ipbig_next;
    logic [15:0]           fr_reg, fr_next;
    logic [30:0]           y_reg, y_next;
    logic [3:0]            k_reg, k_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    logic [16:0]           out_w_reg, out_w_next;
    logic                  out_last_reg, out_last_next;

    logic signed [32:0]    mul_a, mul_b;
    logic signed [65:0]    mul_p;
    iter_ctl_t             it_ctl;
    logic [ACC_W-1:0]      it_a;
    logic                  it_done;
    logic [EW-1:0]         it_res;

    logic                  wg_we, m_we, x_we, e_we;
    logic [IW-1:0]         ld_addr, rd_addr;
    logic [16:0]           w_clamp, w_rdata;
    logic [31:0]           g_rdata, m_rdata, m_wdata;
    logic [XW-1:0]         x_wdata, x_rdata;
    logic [EW-1:0]         e_wdata, e_rdata;
    logic                  in_xfer;
    logic [CW-1:0]         i_inc_chk;

    function automatic logic [4:0] msb_pos(input logic [16:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int b = 0; b < 17; b++)
        begin
            if (v[b])
            begin
                pos = 5'(b);
            end
        end
        return pos;
    endfunction

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign ld_addr = count_reg[IW-1:0];
    assign rd_addr = i_reg[IW-1:0];
    assign w_clamp = (s_axis_tdata[16:0] > 17'd65536) ? 17'd65536 : s_axis_tdata[16:0];

    slu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    slu_iter u_iter (
        .clk(clk), .rst_n(rst_n), .ctl(it_ctl), .op_a(it_a),
        .op_b(sum_reg), .done(it_done), .result(it_res)
    );

    slu_ram #(.WIDTH(17), .DEPTH(MAX_LEN)) u_wram (
        .clk(clk), .we(wg_we), .waddr(ld_addr), .wdata(w_clamp),
        .raddr(rd_addr), .rdata(w_rdata)
    );
    slu_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_gram (
        .clk(clk), .we(wg_we), .waddr(ld_addr), .wdata(s_axis_tdata[48:17]),
        .raddr(rd_addr), .rdata(g_rdata)
    );
    slu_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_mram (
        .clk(clk), .we(m_we), .waddr(rd_addr), .wdata(m_wdata),
        .raddr(rd_addr), .rdata(m_rdata)
    );
    slu_ram #(.WIDTH(XW), .DEPTH(MAX_LEN)) u_xram (
        .clk(clk), .we(x_we), .waddr(rd_addr), .wdata(x_wdata),
        .raddr(rd_addr), .rdata(x_rdata)
    );
    slu_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_eram (
        .clk(clk), .we(e_we), .waddr(rd_addr), .wdata(e_wdata),
        .raddr(rd_addr), .rdata(e_rdata)
    );

    always_comb
    begin
        logic [CW-1:0]       i_inc;
        logic                last_i;
        logic [31:0]         mm;
        logic [15:0]         frac_n;
        logic signed [65:0]  sum66;
        logic signed [21:0]  diff;
        logic signed [49:0]  x_full;
        logic signed [25:0]  v_sum;
        logic signed [26:0]  xn;
        logic signed [24:0]  d_val;
        logic signed [26:0]  t_exp;
        logic [26:0]         u_val;
        logic [30:0]         y_half;
        logic [EW-1:0]       e_val;

        i_inc  = i_reg + CW'(1);
        last_i = (i_inc == n_reg);
        mm     = mul_p[61:30];
        frac_n = {lg_frac_reg[14:0], mm[31]};
        sum66  = acc_reg + mul_p;
        diff   = $signed({1'b0, logw_reg}) - $signed({1'b0, lmax_reg});
        x_full = mul_p[65:16];
        v_sum  = 26'(s_reg) + 26'($signed(mul_p[40:16]));
        xn     = 27'(x_reg) - 27'($signed(mul_p[41:16]));
        d_val  = 25'($signed(x_rdata)) - 25'(xmax_reg);
        t_exp  = mul_p[42:16];
        u_val  = 27'(-t_exp);
        y_half = fr_reg[k_reg] ? (y_reg >> 1) : y_reg;
        e_val  = ipbig_reg ? '0 : (y_reg >> ip_reg);

        state_next     = state_reg;
        lr_next        = lr_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        wd_next        = wd_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        largest_next   = largest_reg;
        mvalid_next    = mvalid_reg;
        lsrc_max_next  = lsrc_max_reg;
        lmax_next      = lmax_reg;
        logw_next      = logw_reg;
        lg_m_next      = lg_m_reg;
        lg_e_next      = lg_e_reg;
        lg_frac_next   = lg_frac_reg;
        lg_cnt_next    = lg_cnt_reg;
        w_next         = w_reg;
        g_next         = g_reg;
        m_next         = m_reg;
        ga_next        = ga_reg;
        acc_next       = acc_reg;
        s_next         = s_reg;
        x_next         = x_reg;
        xmax_next      = xmax_reg;
        ip_next        = ip_reg;
        ipbig_next     = ipbig_reg;
        fr_next        = fr_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_w_next     = out_w_reg;
        out_last_next  = out_last_reg;
        mul_a          = '0;
        mul_b          = '0;
        it_ctl         = '{start: 1'b0, mode: ITER_SQRT};
        it_a           = '0;
        wg_we          = 1'b0;
        m_we           = 1'b0;
        x_we           = 1'b0;
        e_we           = 1'b0;
        m_wdata        = 32'(sum66 >>> 16);
        x_wdata        = x_reg;
        e_wdata        = e_val;
        s_axis_tready  = (state_reg == ST_LOAD);

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_RATE: lr_next = cfg_data;
                CFG_BLEND:     b1_next = cfg_data;
                CFG_MDECAY:    b2_next = cfg_data;
                CFG_WDECAY:    wd_next = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        wg_we = 1'b1;
                        if (s_axis_tuser)
                        begin
                            mvalid_next[ld_addr] = 1'b0;
                        end
                        if (w_clamp > largest_reg)
                        begin
                            largest_next = w_clamp;
                        end
                        count_next = count_reg + CW'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = ST_LMAX;
                    end
                end
            end
            ST_LMAX:
            begin
                n_next    = count_reg;
                i_next    = '0;
                xmax_next = LOG_FLOOR;
                sum_next  = '0;
                if (largest_reg == 17'd0)
                begin
                    lmax_next  = '0;
                    state_next = ST_E_RD;
                end
                else
                begin
                    lsrc_max_next = 1'b1;
                    lg_e_next     = msb_pos(largest_reg);
                    lg_m_next     = 31'({14'b0, largest_reg} << (5'd30 - msb_pos(largest_reg)));
                    lg_frac_next  = '0;
                    lg_cnt_next   = '0;
                    state_next    = ST_LG_SQ;
                end
            end
            ST_LG_SQ:
            begin
                mul_a      = 33'(lg_m_reg);
                mul_b      = 33'(lg_m_reg);
                state_next = ST_LG_AC;
            end
            ST_LG_AC:
            begin
                lg_frac_next = frac_n;
                lg_m_next    = mm[31] ? mm[31:1] : mm[30:0];
                lg_cnt_next  = lg_cnt_reg + 4'd1;
                if (lg_cnt_reg == 4'd15)
                begin
                    if (lsrc_max_reg)
                    begin
                        lmax_next  = {lg_e_reg, frac_n};
                        state_next = ST_E_RD;
                    end
                    else
                    begin
                        logw_next  = {lg_e_reg, frac_n};
                        state_next = ST_E_LN;
                    end
                end
                else
                begin
                    state_next = ST_LG_SQ;
                end
            end
            ST_E_RD:
            begin
                state_next = ST_E_LD;
            end
            ST_E_LD:
            begin
                w_next     = w_rdata;
                g_next     = $signed(g_rdata);
                m_next     = mvalid_reg[rd_addr] ? $signed(m_rdata) : 32'sd0;
                mul_a      = 33'(w_rdata);
                mul_b      = 33'(ONE_Q16 - 33'(w_rdata));
                state_next = ST_E_F;
            end
            ST_E_F:
            begin
                mul_a      = 33'(g_reg);
                mul_b      = 33'(mul_p[32:16]);
                state_next = ST_E_GA;
            end
            ST_E_GA:
            begin
                ga_next    = 32'(mul_p >>> 16);
                mul_a      = 33'(b1_reg);
                mul_b      = 33'(m_reg);
                state_next = ST_E_A1;
            end
            ST_E_A1:
            begin
                acc_next   = mul_p;
                mul_a      = 33'(ONE_Q16 - 33'(b1_reg));
                mul_b      = 33'(ga_reg);
                state_next = ST_E_A2;
            end
            ST_E_A2:
            begin
                if (sum66 > 66'sd0)
                begin
                    s_next = 18'sd65536;
                end
                else if (sum66 < 66'sd0)
                begin
                    s_next = -18'sd65536;
                end
                else
                begin
                    s_next = 18'sd0;
                end
                mul_a      = 33'(b2_reg);
                mul_b      = 33'(m_reg);
                state_next = ST_E_M1;
            end
            ST_E_M1:
            begin
                acc_next   = mul_p;
                mul_a      = 33'(ONE_Q16 - 33'(b2_reg));
                mul_b      = 33'(ga_reg);
                state_next = ST_E_M2;
            end
            ST_E_M2:
            begin
                m_we                 = 1'b1;
                mvalid_next[rd_addr] = 1'b1;
                if (w_reg == 17'd0)
                begin
                    x_next     = LOG_FLOOR;
                    state_next = ST_E_WD;
                end
                else
                begin
                    lsrc_max_next = 1'b0;
                    lg_e_next     = msb_pos(w_reg);
                    lg_m_next     = 31'({14'b0, w_reg} << (5'd30 - msb_pos(w_reg)));
                    lg_frac_next  = '0;
                    lg_cnt_next   = '0;
                    state_next    = ST_LG_SQ;
                end
            end
            ST_E_LN:
            begin
                mul_a      = 33'(diff);
                mul_b      = LN2_Q16;
                state_next = ST_E_X;
            end
            ST_E_X:
            begin
                x_next     = (x_full < 50'(LOG_FLOOR)) ? LOG_FLOOR : x_full[XW-1:0];
                state_next = ST_E_WD;
            end
            ST_E_WD:
            begin
                mul_a      = 33'(wd_reg);
                mul_b      = 33'(x_reg);
                state_next = ST_E_S;
            end
            ST_E_S:
            begin
                mul_a      = 33'(lr_reg);
                mul_b      = 33'(v_sum);
                state_next = ST_E_X2;
            end
            ST_E_X2:
            begin
                if (xn < 27'(LOG_FLOOR))
                begin
                    x_wdata = LOG_FLOOR;
                end
                else if (xn > 27'(LOG_CEIL))
                begin
                    x_wdata = LOG_CEIL;
                end
                else
                begin
                    x_wdata = xn[XW-1:0];
                end
                x_we = 1'b1;
                if ($signed(x_wdata) > xmax_reg)
                begin
                    xmax_next = $signed(x_wdata);
                end
                if (last_i)
                begin
                    i_next     = '0;
                    state_next = ST_X_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_E_RD;
                end
            end
            ST_X_RD:
            begin
                state_next = ST_X_LD;
            end
            ST_X_LD:
            begin
                mul_a      = 33'(d_val);
                mul_b      = LOG2E_Q16;
                state_next = ST_X_T;
            end
            ST_X_T:
            begin
                ipbig_next = (u_val[26:16] >= 11'd31);
                ip_next    = u_val[20:16];
                fr_next    = u_val[15:0];
                y_next     = 31'd1 << 30;
                k_next     = '0;
                state_next = ST_X_SQ;
            end
            ST_X_SQ:
            begin
                it_ctl     = '{start: 1'b1, mode: ITER_SQRT};
                it_a       = {y_half, 30'b0};
                state_next = ST_X_SQW;
            end
            ST_X_SQW:
            begin
                if (it_done)
                begin
                    y_next = it_res;
                    k_next = k_reg + 4'd1;
                    state_next = (k_reg == 4'd15) ? ST_X_E : ST_X_SQ;
                end
            end
            ST_X_E:
            begin
                e_we     = 1'b1;
                sum_next = sum_reg + SUM_W'(e_val);
                if (last_i)
                begin
                    i_next     = '0;
                    state_next = ST_D_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_X_RD;
                end
            end
            ST_D_RD:
            begin
                state_next = ST_D_ST;
            end
            ST_D_ST:
            begin
                it_ctl     = '{start: 1'b1, mode: ITER_DIV};
                it_a       = ACC_W'({e_rdata, 16'b0}) + ACC_W'(sum_reg >> 1);
                state_next = ST_D_W;
            end
            ST_D_W:
            begin
                if (it_done)
                begin
                    out_w_next     = it_res[16:0];
                    out_last_next  = last_i;
                    out_valid_next = 1'b1;
                    state_next     = ST_D_OUT;
                end
            end
            ST_D_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    if (last_i)
                    begin
                        count_next   = '0;
                        largest_next = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = ST_D_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            lr_reg        <= STEP_RATE_RST;
            b1_reg        <= BLEND_RST;
            b2_reg        <= MDECAY_RST;
            wd_reg        <= WDECAY_RST;
            count_reg     <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            largest_reg   <= '0;
            mvalid_reg    <= '0;
            lsrc_max_reg  <= 1'b0;
            lg_cnt_reg    <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lr_reg        <= lr_next;
            b1_reg        <= b1_next;
            b2_reg        <= b2_next;
            wd_reg        <= wd_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
            largest_reg   <= largest_next;
            mvalid_reg    <= mvalid_next;
            lsrc_max_reg  <= lsrc_max_next;
            lg_cnt_reg    <= lg_cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lmax_reg     <= lmax_next;
        logw_reg     <= logw_next;
        lg_m_reg     <= lg_m_next;
        lg_e_reg     <= lg_e_next;
        lg_frac_reg  <= lg_frac_next;
        w_reg        <= w_next;
        g_reg        <= g_next;
        m_reg        <= m_next;
        ga_reg       <= ga_next;
        acc_reg      <= acc_next;
        s_reg        <= s_next;
        x_reg        <= x_next;
        xmax_reg     <= xmax_next;
        ip_reg       <= ip_next;
        ipbig_reg    <= ipbig_next;
        fr_reg       <= fr_next;
        y_reg        <= y_next;
        sum_reg      <= sum_next;
        out_w_reg    <= out_w_next;
        out_last_reg <= out_last_next;
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, 6'(i_reg), out_w_reg};
    assign m_axis_tlast  = out_last_reg;

    assign i_inc_chk = i_reg + CW'(1);

    `ASSERT_ALWAYS(a_load_xor_emit, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= MAX_CNT, "element count beyond depth")
    `ASSERT_ALWAYS(a_last_at_end, !(m_axis_tvalid && m_axis_tlast) || (i_inc_chk == n_reg), "tlast off the final slot")
    `ASSERT_NEXT(a_div_to_out, (state_reg == ST_D_W) && it_done, m_axis_tvalid, "quotient not presented")

endmodule
